@@ src/ipm_pkg.sv @@
// ----------------------------------------------------------------------------
// Isomorphic pattern matcher package
// Shared widths, defaults, string kinds and the relabel control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ipm_pkg;

   localparam int SYMBOL_WIDTH         = 8;
   localparam int SYMBOL_SPACE         = 1 << SYMBOL_WIDTH;
   localparam int CODE_WIDTH           = 8;
   localparam int NEXT_CODE_WIDTH      = CODE_WIDTH + 1;
   localparam int MAX_LEN_DEFAULT      = 64;
   localparam int SYMBOL_COUNT_DEFAULT = 256;

   typedef logic [SYMBOL_WIDTH-1:0] symbol_type;
   typedef logic [CODE_WIDTH-1:0]   code_type;

   // Which string a byte belongs to.
   typedef enum logic {
      KIND_PATTERN = 1'b0,
      KIND_WORD    = 1'b1
   } kind_type;

   // Control from the top level to the relabel unit.
   typedef struct packed {
      logic accept;   // a new byte enters the input register
      logic fire;     // the byte in the input register is processed
      logic start;    // that byte opens a new string
   } relabel_ctl_type;

endpackage

`default_nettype wire

@@ src/ipm_relabel.sv @@
// ----------------------------------------------------------------------------
// Isomorphic pattern matcher relabel unit
// Gives each byte a dense code in order of first appearance within a string.
// Seen bits are flip-flops so a new string clears them at once; the codes
// live in a memory that is read when a byte is accepted, with forwarding of
// the code being written by the byte ahead of it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipm_relabel
   import ipm_pkg::*;
#(
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire relabel_ctl_type ctl,
   input  wire symbol_type      acc_symbol,
   input  wire symbol_type      cur_symbol,
   output code_type             code
);

   localparam int IW = $clog2(SYMBOL_COUNT);

   typedef logic [SYMBOL_SPACE-1:0][IW-1:0] sym_map_type;

   // Folds a raw byte onto the symbol alphabet; built at elaboration.
   function automatic sym_map_type build_map();
      sym_map_type m;
      for (int i = 0; i < SYMBOL_SPACE; i++) begin
         m[i] = IW'(i % SYMBOL_COUNT);
      end
      return m;
   endfunction

   localparam sym_map_type SYM_MAP = build_map();

   logic [SYMBOL_COUNT-1:0]    seen_ff;
   logic [SYMBOL_COUNT-1:0]    seen_cur;
   logic [SYMBOL_COUNT-1:0]    seen_in;
   logic [NEXT_CODE_WIDTH-1:0] next_code_ff;
   logic [NEXT_CODE_WIDTH-1:0] next_cur;
   logic [NEXT_CODE_WIDTH-1:0] next_code_in;
   code_type                   code_mem [SYMBOL_COUNT];
   code_type                   rd_data_ff;
   logic [IW-1:0]              acc_idx;
   logic [IW-1:0]              cur_idx;
   logic                       hit;
   logic                       wr_en;
   logic                       forward;

   assign acc_idx = SYM_MAP[acc_symbol];
   assign cur_idx = SYM_MAP[cur_symbol];

   always_comb begin
      seen_cur = ctl.start ? '0 : seen_ff;
      next_cur = ctl.start ? '0 : next_code_ff;
      hit      = seen_cur[cur_idx];
      code     = hit ? rd_data_ff : next_cur[CODE_WIDTH-1:0];
      seen_in  = seen_cur;
      seen_in[cur_idx] = 1'b1;
      if (!hit && (next_cur < NEXT_CODE_WIDTH'(SYMBOL_SPACE))) begin
         next_code_in = next_cur + NEXT_CODE_WIDTH'(1);
      end else begin
         next_code_in = next_cur;
      end
      wr_en   = ctl.fire && !hit;
      forward = wr_en && (cur_idx == acc_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         next_code_ff <= '0;
      end else if (ctl.fire) begin
         seen_ff      <= seen_in;
         next_code_ff <= next_code_in;
      end
   end

   // A byte that repeats the one just ahead of it takes the code being
   // written this cycle rather than the stale memory word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem[cur_idx] <= next_cur[CODE_WIDTH-1:0];
      end
      if (ctl.accept) begin
         rd_data_ff <= forward ? next_cur[CODE_WIDTH-1:0] : code_mem[acc_idx];
      end
   end

endmodule

`default_nettype wire

@@ src/isomorphic_pattern_matcher_top.sv @@
// ----------------------------------------------------------------------------
// Isomorphic pattern matcher
// Relabels pattern and word strings by first appearance of each byte and
// reports, at the last byte of each word, whether it matches the pattern.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_stall  req_type, req_symbol, req_is_last
//   rsp      out  rsp_valid/rsp_stall  rsp_is_match, rsp_pattern_too_long
//
// One byte is taken per cycle while req_stall is low. A byte passes an input
// register (code memory read), a compare stage (pattern memory read) and the
// result register, which receives the verdict of its word's last byte.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled result holds the result register; bytes that give no result
// keep flowing until the compare stage holds a word end that cannot leave.
// ----------------------------------------------------------------------------
`default_nettype none

module isomorphic_pattern_matcher_top
   import ipm_pkg::*;
#(
   parameter int MAX_LEN      = MAX_LEN_DEFAULT,
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_type,
   input  wire symbol_type req_symbol,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_is_match,
   output logic            rsp_pattern_too_long
);

   localparam int PW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   // Input register stage.
   logic            s1_valid_ff;
   kind_type        s1_kind_ff;
   symbol_type      s1_symbol_ff;
   logic            s1_last_ff;
   // String state.
   logic            in_string_ff;
   kind_type        string_kind_ff;
   logic [PW-1:0]   position_ff;
   logic [PW-1:0]   pattern_length_ff;
   logic            pattern_overflow_ff;
   logic            mismatch_ff;
   // Compare stage.
   logic            s2_valid_ff;
   logic            s2_word_ff;
   logic            s2_last_ff;
   logic            s2_start_ff;
   code_type        s2_code_ff;
   logic            s2_check_ff;
   logic            s2_len_eq_ff;
   logic            s2_ovf_ff;
   code_type        pat_rd_ff;
   code_type        pat_mem [MAX_LEN];
   // Result register.
   logic            rsp_valid_ff;
   logic            rsp_is_match_ff;
   logic            rsp_too_long_ff;

   logic            accept;
   logic            s1_fire;
   logic            s2_fire;
   logic            s2_result;
   logic            out_ready;
   logic            start;
   logic            is_pattern;
   logic [PW-1:0]   pos_cur;
   logic [PW-1:0]   pos_next;
   logic [PW-1:0]   plen_cur;
   logic            ovf_cur;
   logic            in_range;
   logic            mismatch_in;
   code_type        code;
   relabel_ctl_type relabel_ctl;

   // Handshake and stage movement.
   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      s2_result = s2_valid_ff && s2_word_ff && s2_last_ff;
      s2_fire   = s2_valid_ff && (!s2_result || out_ready);
      s1_fire   = s1_valid_ff && (!s2_valid_ff || s2_fire);
      req_stall = s1_valid_ff && !s1_fire;
      accept    = req_valid && !req_stall;
   end

   // Stage one: string bookkeeping for the byte in the input register.
   always_comb begin
      start      = !in_string_ff || (string_kind_ff != s1_kind_ff);
      is_pattern = (s1_kind_ff == KIND_PATTERN);
      pos_cur    = start ? '0 : position_ff;
      in_range   = (pos_cur < PW'(MAX_LEN));
      pos_next   = in_range ? pos_cur + PW'(1) : pos_cur;
      plen_cur   = (start && is_pattern) ? '0 : pattern_length_ff;
      ovf_cur    = (start && is_pattern) ? 1'b0 : pattern_overflow_ff;
   end

   assign relabel_ctl = '{accept: accept, fire: s1_fire, start: start};

   ipm_relabel #(
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) u_relabel (
      .clock      (clock),
      .reset      (reset),
      .ctl        (relabel_ctl),
      .acc_symbol (req_symbol),
      .cur_symbol (s1_symbol_ff),
      .code       (code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= kind_type'(req_type);
         s1_symbol_ff <= req_symbol;
         s1_last_ff   <= req_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff        <= 1'b0;
         string_kind_ff      <= KIND_PATTERN;
         position_ff         <= '0;
         pattern_length_ff   <= '0;
         pattern_overflow_ff <= 1'b0;
      end else if (s1_fire) begin
         in_string_ff   <= !s1_last_ff;
         string_kind_ff <= s1_kind_ff;
         position_ff    <= pos_next;
         if (is_pattern) begin
            pattern_overflow_ff <= ovf_cur || !in_range;
            pattern_length_ff   <= s1_last_ff ? pos_next : plen_cur;
         end
      end
   end

   // Pattern codes: written by pattern bytes, read by word bytes.
   always_ff @(posedge clock) begin
      if (s1_fire && is_pattern && in_range) begin
         pat_mem[pos_cur[AW-1:0]] <= code;
      end
      if (s1_fire && !is_pattern && in_range) begin
         pat_rd_ff <= pat_mem[pos_cur[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_fire) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         s2_word_ff   <= !is_pattern;
         s2_last_ff   <= s1_last_ff;
         s2_start_ff  <= start;
         s2_code_ff   <= code;
         s2_check_ff  <= in_range && (pos_cur < plen_cur);
         s2_len_eq_ff <= (pos_next == plen_cur);
         s2_ovf_ff    <= ovf_cur;
      end
   end

   // Stage two: a word byte out of range or past the pattern end, or with
   // a different code, spoils the whole word.
   always_comb begin
      mismatch_in = (s2_start_ff ? 1'b0 : mismatch_ff) || !s2_check_ff ||
                    (pat_rd_ff != s2_code_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mismatch_ff <= 1'b0;
      end else if (s2_fire && s2_word_ff) begin
         mismatch_ff <= mismatch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_fire && s2_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && s2_result) begin
         rsp_is_match_ff <= !mismatch_in && s2_len_eq_ff && !s2_ovf_ff;
         rsp_too_long_ff <= s2_ovf_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_match         = rsp_is_match_ff;
   assign rsp_pattern_too_long = rsp_too_long_ff;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Isomorphic pattern matcher testbench
// Streams pattern and word strings into the matcher. Each byte is run through
// a relabel-and-compare predictor, and every verdict is compared with the
// oldest predicted one. Directed strings cover the corner cases, then random
// traffic runs under four sender and receiver stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import ipm_pkg::*;

   localparam int MAX_LEN = MAX_LEN_DEFAULT;

   typedef struct {
      logic is_match;
      logic too_long;
   } verdict_t;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_type = 1'b0;
   symbol_type req_symbol = '0;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_match;
   logic       rsp_pattern_too_long;

   isomorphic_pattern_matcher_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_symbol           (req_symbol),
      .req_is_last          (req_is_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_is_match         (rsp_is_match),
      .rsp_pattern_too_long (rsp_pattern_too_long)
   );

   // Relabel state of the predictor.
   bit                         seen_sym [SYMBOL_SPACE];
   code_type                   sym_code [SYMBOL_SPACE];
   logic [NEXT_CODE_WIDTH-1:0] codes_issued = '0;
   code_type                   stored_codes [MAX_LEN];
   int                         stored_len = 0;
   bit                         stored_overflow = 1'b0;
   int                         str_pos = 0;
   bit                         str_mismatch = 1'b0;
   bit                         str_open = 1'b0;
   kind_type                   str_kind = KIND_PATTERN;

   verdict_t   pending_verdicts [$];
   verdict_t   oldest_verdict;
   symbol_type cur_pattern [$];

   int fail_count = 0;
   int bytes_sent = 0;
   int verdict_count = 0;
   int match_count = 0;
   int overlong_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("verdict transfer with no verdict pending");
            fail_count++;
         end else begin
            oldest_verdict = pending_verdicts.pop_front();
            verdict_count++;
            if (rsp_is_match) match_count++;
            if (rsp_pattern_too_long) overlong_count++;
            if (rsp_is_match !== oldest_verdict.is_match) begin
               $error("is_match expected %0b actual %0b", oldest_verdict.is_match,
                      rsp_is_match);
               fail_count++;
            end
            if (rsp_pattern_too_long !== oldest_verdict.too_long) begin
               $error("pattern_too_long expected %0b actual %0b",
                      oldest_verdict.too_long, rsp_pattern_too_long);
               fail_count++;
            end
         end
      end
   end

   // Relabels one byte and compares it with the stored pattern codes.
   function automatic void relabel_and_compare(kind_type kind, symbol_type sym,
                                               logic is_end);
      code_type code;
      verdict_t verdict;
      if (!str_open || str_kind != kind) begin
         foreach (seen_sym[i]) seen_sym[i] = 1'b0;
         codes_issued = '0;
         str_pos = 0;
         str_mismatch = 1'b0;
         str_open = 1'b1;
         str_kind = kind;
         if (kind == KIND_PATTERN) begin
            stored_len = 0;
            stored_overflow = 1'b0;
         end
      end
      if (!seen_sym[sym]) begin
         seen_sym[sym] = 1'b1;
         sym_code[sym] = codes_issued[CODE_WIDTH-1:0];
         if (codes_issued < (1 << CODE_WIDTH)) codes_issued = codes_issued + 1'b1;
      end
      code = sym_code[sym];
      if (kind == KIND_PATTERN) begin
         if (str_pos < MAX_LEN) begin
            stored_codes[str_pos] = code;
            str_pos++;
         end else begin
            stored_overflow = 1'b1;
         end
         if (is_end) begin
            stored_len = str_pos;
            str_open = 1'b0;
         end
      end else begin
         if (str_pos < MAX_LEN) begin
            if (str_pos >= stored_len) str_mismatch = 1'b1;
            else if (stored_codes[str_pos] != code) str_mismatch = 1'b1;
            str_pos++;
         end else begin
            str_mismatch = 1'b1;
         end
         if (is_end) begin
            str_open = 1'b0;
            verdict.is_match = !str_mismatch && str_pos == stored_len && !stored_overflow;
            verdict.too_long = stored_overflow;
            pending_verdicts = {pending_verdicts, verdict};
         end
      end
   endfunction

   task automatic send_byte(input kind_type kind, input symbol_type sym, input logic is_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_symbol <= sym;
      req_is_last <= is_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      relabel_and_compare(kind, sym, is_end);
      bytes_sent++;
   endtask

   task automatic send_string(input kind_type kind, input symbol_type str [$],
                              input bit with_end);
      foreach (str[i]) send_byte(kind, str[i], with_end && i == str.size() - 1);
   endtask

   // Lowers valid and waits until every verdict is in or the wait times out.
   task automatic wait_for_verdicts();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Random string over a few distinct bytes so that repeats are common.
   function automatic void make_string(output symbol_type str [$], input int len,
                                       input int alphabet);
      symbol_type base;
      symbol_type stride;
      base = symbol_type'($urandom);
      stride = symbol_type'($urandom | 1);
      str = {};
      repeat (len) str = {str, symbol_type'(base + stride * $urandom_range(alphabet - 1))};
   endfunction

   // An odd multiplier plus an offset is a bijection on bytes.
   function automatic void relabel_copy(output symbol_type dst [$], input symbol_type src [$]);
      symbol_type mult;
      symbol_type offset;
      mult = symbol_type'($urandom | 1);
      offset = symbol_type'($urandom);
      dst = {};
      foreach (src[i]) dst = {dst, symbol_type'(src[i] * mult + offset)};
   endfunction

   task automatic send_new_pattern(input int len);
      make_string(cur_pattern, len, $urandom_range(1, 8));
      send_string(KIND_PATTERN, cur_pattern, 1'b1);
   endtask

   task automatic test_directed_cases();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      // A word before any pattern never matches.
      send_string(KIND_WORD, '{8'h00}, 1'b1);
      send_string(KIND_PATTERN, '{8'h00, 8'hFF, 8'h80, 8'h00}, 1'b1);
      send_string(KIND_WORD, '{8'h11, 8'h22, 8'h33, 8'h11}, 1'b1);
      send_string(KIND_WORD, '{8'h11, 8'h22, 8'h33, 8'h22}, 1'b1);
      send_string(KIND_WORD, '{8'h11, 8'h22, 8'h33}, 1'b1);
      send_string(KIND_WORD, '{8'h11, 8'h22, 8'h33, 8'h11, 8'h44}, 1'b1);
      // An unfinished word is dropped when a pattern byte arrives.
      send_byte(KIND_WORD, 8'h55, 1'b0);
      send_string(KIND_PATTERN, '{8'h7F}, 1'b1);
      send_string(KIND_WORD, '{8'hAA}, 1'b1);
      // An unfinished pattern leaves nothing to match against.
      send_byte(KIND_PATTERN, 8'h01, 1'b0);
      send_string(KIND_WORD, '{8'h02}, 1'b1);
      wait_for_verdicts();
   endtask

   task automatic test_long_strings();
      symbol_type word [$];
      symbol_type every_byte [$];
      send_new_pattern(MAX_LEN);
      relabel_copy(word, cur_pattern);
      send_string(KIND_WORD, word, 1'b1);
      word = {word, symbol_type'(word[0] + 8'd1)};
      send_string(KIND_WORD, word, 1'b1);
      send_new_pattern(MAX_LEN + 2);
      relabel_copy(word, cur_pattern);
      send_string(KIND_WORD, word, 1'b1);
      send_string(KIND_WORD, '{8'h3C}, 1'b1);
      // All 256 byte values in one string run the code counter to its end.
      for (int i = 0; i < SYMBOL_SPACE; i++) every_byte = {every_byte, symbol_type'(i)};
      relabel_copy(cur_pattern, every_byte);
      send_string(KIND_PATTERN, cur_pattern, 1'b1);
      relabel_copy(word, cur_pattern);
      send_string(KIND_WORD, word, 1'b1);
      send_new_pattern(MAX_LEN - 1);
      relabel_copy(word, cur_pattern);
      send_string(KIND_WORD, word, 1'b1);
      wait_for_verdicts();
   endtask

   // The receiver holds off while one-byte words keep coming, so the
   // block fills up and has to stall its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_new_pattern(1);
      hold_request = 150;
      repeat (40) send_byte(KIND_WORD, symbol_type'($urandom), 1'b1);
      wait_for_verdicts();
   endtask

   task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                      input int n_bytes);
      int target;
      int pick;
      symbol_type word [$];
      send_idle_pct = sender_idle;
      recv_stall_pct = receiver_stall;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 12 || cur_pattern.size() == 0) begin
            if ($urandom_range(99) < 4) send_new_pattern($urandom_range(MAX_LEN - 4, MAX_LEN + 6));
            else send_new_pattern($urandom_range(1, 12));
         end else if (pick < 62) begin
            relabel_copy(word, cur_pattern);
            send_string(KIND_WORD, word, 1'b1);
         end else if (pick < 80) begin
            relabel_copy(word, cur_pattern);
            case ($urandom_range(2))
               0: word[$urandom_range(word.size() - 1)] = symbol_type'($urandom);
               1: void'(word.pop_back());
               default: word = {word, symbol_type'($urandom)};
            endcase
            if (word.size() == 0) word = {word, symbol_type'($urandom)};
            send_string(KIND_WORD, word, 1'b1);
         end else if (pick < 92) begin
            make_string(word, $urandom_range(1, 12), $urandom_range(1, 8));
            send_string(KIND_WORD, word, 1'b1);
         end else begin
            // A string cut short by a byte of the other kind.
            make_string(word, $urandom_range(1, 4), 4);
            if ($urandom_range(1)) begin
               send_string(KIND_WORD, word, 1'b0);
            end else begin
               send_string(KIND_PATTERN, word, 1'b0);
               make_string(word, $urandom_range(1, 4), 4);
               send_string(KIND_WORD, word, 1'b1);
            end
            send_new_pattern($urandom_range(1, 12));
         end
      end
      wait_for_verdicts();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_long_strings();
      test_backpressure();
      test_random_traffic(0, 0, 170);
      test_random_traffic(64, 0, 170);
      test_random_traffic(0, 64, 170);
      test_random_traffic(33, 33, 170);
      repeat (20) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", pending_verdicts.size());
         fail_count++;
      end
      $display("Sent %0d bytes of patterns and words; checked %0d verdicts", bytes_sent,
               verdict_count);
      $display("(%0d matches, %0d against an overlong pattern) under four stall mixes.",
               match_count, overlong_count);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
src/ipm_pkg.sv
src/ipm_relabel.sv
src/isomorphic_pattern_matcher_top.sv
tb/tb_top.sv
